// File: sv/obb_separating_axis_test_defines.svh
// Assertion macros shared by the checker.
`ifndef OBB_SEPARATING_AXIS_TEST_DEFINES_SVH
`define OBB_SEPARATING_AXIS_TEST_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define OBB_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication.
`define OBB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// File: sv/obb_pkg.sv
`timescale 1ns / 1ps
package obb_pkg;
    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int NUM_AXES       = 15;
    localparam int WORD_W         = 48;
endpackage

// File: sv/obb_axis_cell.sv
`timescale 1ns / 1ps
// One cell of the chain: forms its own axis, projects the six rows and the
// centre difference on it, and clears the running overlap flag when the axis
// separates. Work is split over three register stages inside the cell.
module obb_axis_cell #(
    parameter int CW      = 16,
    parameter int AXIS    = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic                in_hit,
    input  logic [18*CW-1:0]    in_rows,
    input  logic [3*(CW+1)-1:0] in_d,
    output logic                out_valid,
    output logic                out_hit,
    output logic [18*CW-1:0]    out_rows,
    output logic [3*(CW+1)-1:0] out_d
);
    import obb_pkg::*;

    localparam int SW = 2 * CW + 1;            // axis component width
    localparam int PW = SW + CW + 3;           // one projection
    localparam int DW = SW + CW + 4;           // centre projection doubled
    localparam int TW = PW + 3;                // sum of six magnitudes

    function automatic logic signed [CW-1:0] comp(input logic [18*CW-1:0] r,
                                                  input int k, input int c);
        comp = r[(3*k+c)*CW +: CW];
    endfunction

    // Stage 1: axis.
    logic signed [SW-1:0] s_next [3];
    logic signed [SW-1:0] s_reg  [3];

    if (AXIS < 6)
    begin : g_face
        always_comb
        begin
            for (int c = 0; c < 3; c++)
                s_next[c] = SW'(comp(in_rows, AXIS, c));
        end
    end
    else
    begin : g_cross
        localparam int AI = (AXIS - 6) / 3;
        localparam int BJ = 3 + (AXIS - 6) % 3;
        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                s_next[c] = SW'(comp(in_rows, AI, (c+1)%3)
                              * comp(in_rows, BJ, (c+2)%3))
                          - SW'(comp(in_rows, AI, (c+2)%3)
                              * comp(in_rows, BJ, (c+1)%3));
            end
        end
    end

    logic [18*CW-1:0]    rows1_reg;
    logic [3*(CW+1)-1:0] d1_reg;
    logic                v1_reg, h1_reg;

    // Stage 2: products.
    logic signed [SW+CW-1:0] p_reg [7][3];
    logic [18*CW-1:0]    rows2_reg;
    logic [3*(CW+1)-1:0] d2_reg;
    logic                v2_reg, h2_reg;

    // Stage 3: magnitudes summed and compared.
    logic [TW-1:0] sum_c;
    logic [DW-1:0] dist_c;
    logic signed [PW-1:0] pj;
    logic signed [DW-1:0] dj;
    always_comb
    begin
        sum_c = '0;
        for (int k = 0; k < 6; k++)
        begin
            pj = PW'(p_reg[k][0]) + PW'(p_reg[k][1]) + PW'(p_reg[k][2]);
            sum_c = sum_c + TW'(pj < 0 ? -pj : pj);
        end
        dj = DW'(p_reg[6][0]) + DW'(p_reg[6][1]) + DW'(p_reg[6][2]);
        dist_c = (dj < 0 ? -dj : dj) << 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid; v2_reg <= v1_reg; out_valid <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++) s_reg[c] <= s_next[c];
            rows1_reg <= in_rows; d1_reg <= in_d; h1_reg <= in_hit;
            for (int k = 0; k < 6; k++)
                for (int c = 0; c < 3; c++)
                    p_reg[k][c] <= s_reg[c] * comp(rows1_reg, k, c);
            for (int c = 0; c < 3; c++)
                p_reg[6][c] <= s_reg[c] * $signed(d1_reg[c*(CW+1) +: CW+1]);
            rows2_reg <= rows1_reg; d2_reg <= d1_reg; h2_reg <= h1_reg;
            out_rows <= rows2_reg; out_d <= d2_reg;
            out_hit  <= h2_reg && !({1'b0, sum_c} < (TW+1)'(dist_c));
        end
    end
endmodule

// File: sv/obb_separating_axis_test.sv
`timescale 1ns / 1ps
// Oriented box overlap test over the fifteen separating axes.
// Input channel: in_valid/in_ready carry one beat holding both boxes, each as
// three axis rows and a centre of three signed components packed x, y, z.
// Output channel: out_valid/out_ready carry one beat with the overlap flag,
// 1 when no axis separates the boxes (touching counts as overlap).
// The boxes travel down a row of fifteen cells, one per axis; each cell forms
// its axis, projects, sums and compares over three register stages and
// clears the running flag if its axis separates. Between acceptance and
// out_valid, the input register loads at the accepting edge and the chain
// adds 45 stages, three per cell. One beat can enter every cycle while the
// receiver does not stall, and the chain of cells sets that rate.
// While the receiver stalls with a result pending, the whole chain holds;
// in_ready stays high as long as the last stage is empty or being taken, so
// bubbles in the chain are not squeezed out but nothing is lost.
// Reset clears every valid bit; no results are pending afterwards.
module obb_separating_axis_test #(
    parameter int COMP_WIDTH = obb_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = obb_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [obb_pkg::WORD_W-1:0] a_row_x,
    input  logic [obb_pkg::WORD_W-1:0] a_row_y,
    input  logic [obb_pkg::WORD_W-1:0] a_row_z,
    input  logic [obb_pkg::WORD_W-1:0] a_centre,
    input  logic [obb_pkg::WORD_W-1:0] b_row_x,
    input  logic [obb_pkg::WORD_W-1:0] b_row_y,
    input  logic [obb_pkg::WORD_W-1:0] b_row_z,
    input  logic [obb_pkg::WORD_W-1:0] b_centre,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      overlap
);
    import obb_pkg::*;

    localparam int CW = COMP_WIDTH;
    localparam int RW = 18 * CW;
    localparam int DWD = 3 * (CW + 1);

    // The result is scale free, so FRAC_BITS does not enter the datapath.

    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // Each word as exactly three components; missing upper bits read as zero.
    logic [3*CW-1:0] ax_w, ay_w, az_w, ac_w, bx_w, by_w, bz_w, bc_w;
    assign ax_w = (3*CW)'(a_row_x);
    assign ay_w = (3*CW)'(a_row_y);
    assign az_w = (3*CW)'(a_row_z);
    assign ac_w = (3*CW)'(a_centre);
    assign bx_w = (3*CW)'(b_row_x);
    assign by_w = (3*CW)'(b_row_y);
    assign bz_w = (3*CW)'(b_row_z);
    assign bc_w = (3*CW)'(b_centre);

    logic [RW-1:0]  rows_reg;
    logic [DWD-1:0] d_reg;
    logic           v0_reg;
    logic [DWD-1:0] d_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            d_next[c*(CW+1) +: CW+1] =
                (CW+1)'($signed(bc_w[c*CW +: CW])) - (CW+1)'($signed(ac_w[c*CW +: CW]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rows_reg <= {bz_w, by_w, bx_w, az_w, ay_w, ax_w};
            d_reg <= d_next;
        end
    end

    logic           v_c [NUM_AXES+1];
    logic           h_c [NUM_AXES+1];
    logic [RW-1:0]  r_c [NUM_AXES+1];
    logic [DWD-1:0] dd_c [NUM_AXES+1];

    assign v_c[0] = v0_reg;
    assign h_c[0] = 1'b1;
    assign r_c[0] = rows_reg;
    assign dd_c[0] = d_reg;

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_cell
        obb_axis_cell #(.CW(CW), .AXIS(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(v_c[g]), .in_hit(h_c[g]), .in_rows(r_c[g]), .in_d(dd_c[g]),
            .out_valid(v_c[g+1]), .out_hit(h_c[g+1]), .out_rows(r_c[g+1]),
            .out_d(dd_c[g+1])
        );
    end

    assign out_valid = v_c[NUM_AXES];
    assign overlap   = h_c[NUM_AXES];
endmodule

// File: sv/obb_checker.sv
`timescale 1ns / 1ps
`include "obb_separating_axis_test_defines.svh"
module obb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic overlap
);
    // A stalled result keeps its value.
    `OBB_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(overlap))
    // The input side is open whenever the output side is empty.
    `OBB_ASSERT_IMPL(a_ready, clk, rst_n, !out_valid, in_ready)
    // A stall at the output closes the input.
    `OBB_ASSERT_IMPL(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready)
endmodule

bind obb_separating_axis_test obb_checker u_obb_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .overlap(overlap)
);

// File: bench/obb_overlap_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the box overlap block, works out the overlap flag
// for every accepted input beat and checks the output beats in order.
module obb_overlap_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [obb_pkg::WORD_W-1:0] a_row_x,
    input  logic [obb_pkg::WORD_W-1:0] a_row_y,
    input  logic [obb_pkg::WORD_W-1:0] a_row_z,
    input  logic [obb_pkg::WORD_W-1:0] a_centre,
    input  logic [obb_pkg::WORD_W-1:0] b_row_x,
    input  logic [obb_pkg::WORD_W-1:0] b_row_y,
    input  logic [obb_pkg::WORD_W-1:0] b_row_z,
    input  logic [obb_pkg::WORD_W-1:0] b_centre,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       overlap,
    output int                         fail_count,
    output int                         pending,
    output int                         overlaps_seen,
    output int                         results_seen
);
    localparam int CW = obb_pkg::COMP_WIDTH_DEF;

    typedef logic signed [127:0] wide_t;
    typedef wide_t vec3_t [3];

    bit overlap_q [$];

    function automatic vec3_t unpack_word(logic [obb_pkg::WORD_W-1:0] word);
        vec3_t v;
        logic signed [CW-1:0] c;
        for (int i = 0; i < 3; i++)
        begin
            c = CW'(word >> (i * CW));
            v[i] = wide_t'(c);
        end
        return v;
    endfunction

    function automatic wide_t dot3(vec3_t s, vec3_t v);
        return s[0] * v[0] + s[1] * v[1] + s[2] * v[2];
    endfunction

    function automatic wide_t mag(wide_t x);
        return (x < 0) ? -x : x;
    endfunction

    // Both sides doubled so the half extents stay integer.
    function automatic bit axis_separates(vec3_t s, vec3_t rows [6], vec3_t d);
        wide_t extent_sum;
        wide_t gap;
        extent_sum = 0;
        for (int k = 0; k < 6; k++)
            extent_sum += mag(dot3(s, rows[k]));
        gap = mag(dot3(s, d));
        return extent_sum < (gap + gap);
    endfunction

    function automatic bit boxes_overlap(logic [obb_pkg::WORD_W-1:0] w [8]);
        vec3_t rows [6];
        vec3_t ca, cb, d, s, u, v;
        bit hit;
        hit = 1'b1;
        rows[0] = unpack_word(w[0]);
        rows[1] = unpack_word(w[1]);
        rows[2] = unpack_word(w[2]);
        ca      = unpack_word(w[3]);
        rows[3] = unpack_word(w[4]);
        rows[4] = unpack_word(w[5]);
        rows[5] = unpack_word(w[6]);
        cb      = unpack_word(w[7]);
        for (int i = 0; i < 3; i++)
            d[i] = cb[i] - ca[i];
        for (int i = 0; i < 6; i++)
            if (axis_separates(rows[i], rows, d))
                hit = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 3; j < 6; j++)
            begin
                u = rows[i];
                v = rows[j];
                s[0] = u[1] * v[2] - u[2] * v[1];
                s[1] = u[2] * v[0] - u[0] * v[2];
                s[2] = u[0] * v[1] - u[1] * v[0];
                if (axis_separates(s, rows, d))
                    hit = 1'b0;
            end
        end
        return hit;
    endfunction

    always @(posedge clk)
    begin
        logic [obb_pkg::WORD_W-1:0] w [8];
        bit expected_flag;
        if (rst_n && in_valid && in_ready)
        begin
            w = '{a_row_x, a_row_y, a_row_z, a_centre, b_row_x, b_row_y, b_row_z, b_centre};
            overlap_q = {overlap_q, boxes_overlap(w)};
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (overlap)
                overlaps_seen++;
            if (overlap_q.size() == 0)
            begin
                $error("output beat with no result expected, overlap=%0d", overlap);
                fail_count++;
            end
            else
            begin
                expected_flag = overlap_q.pop_front();
                if (overlap !== expected_flag)
                begin
                    $error("overlap: expected %0d, actual %0d", expected_flag, overlap);
                    fail_count++;
                end
            end
        end
        pending = overlap_q.size();
    end
endmodule

// File: bench/tb_obb_separating_axis_test.sv
`timescale 1ns / 1ps
// Testbench for the oriented box overlap block. The top only makes stimulus
// and gives the verdict; the checker beside the block predicts and compares.
module tb_obb_separating_axis_test;
    localparam int W          = obb_pkg::WORD_W;
    localparam int N_RANDOM   = 1230;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN      = 100;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] a_row_x, a_row_y, a_row_z, a_centre;
    logic [W-1:0] b_row_x, b_row_y, b_row_z, b_centre;
    logic         out_valid;
    logic         out_ready;
    logic         overlap;

    int fail_count, pending, overlaps_seen, results_seen;
    int beats_sent;
    int idle_cycles;
    int rx_cycle;
    bit in_taken;

    obb_separating_axis_test dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_row_x(a_row_x), .a_row_y(a_row_y), .a_row_z(a_row_z), .a_centre(a_centre),
        .b_row_x(b_row_x), .b_row_y(b_row_y), .b_row_z(b_row_z), .b_centre(b_centre),
        .out_valid(out_valid), .out_ready(out_ready), .overlap(overlap)
    );

    obb_overlap_checker overlap_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_row_x(a_row_x), .a_row_y(a_row_y), .a_row_z(a_row_z), .a_centre(a_centre),
        .b_row_x(b_row_x), .b_row_y(b_row_y), .b_row_z(b_row_z), .b_centre(b_centre),
        .out_valid(out_valid), .out_ready(out_ready), .overlap(overlap),
        .fail_count(fail_count), .pending(pending),
        .overlaps_seen(overlaps_seen), .results_seen(results_seen)
    );

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Record whether the input beat went through at the last rising edge, so
    // that the driver, which works on falling edges, never races the block.
    always @(posedge clk)
        in_taken <= in_valid && in_ready;

    // Packs three signed Q8.8 components, x in the lowest bits.
    function automatic logic [W-1:0] pack3(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    // One random component within +/- span.
    function automatic int rand_comp(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    function automatic logic [W-1:0] rand_row(int span);
        return pack3(rand_comp(span), rand_comp(span), rand_comp(span));
    endfunction

    function automatic logic [W-1:0] rand_bits();
        return W'({$urandom(), $urandom()});
    endfunction

    // Presents one beat at a falling edge and holds it until it is taken.
    // The payload stays put while valid is high.
    task automatic send_boxes(logic [W-1:0] ax, logic [W-1:0] ay, logic [W-1:0] az,
                              logic [W-1:0] ac, logic [W-1:0] bx, logic [W-1:0] by,
                              logic [W-1:0] bz, logic [W-1:0] bc);
        a_row_x  = ax;
        a_row_y  = ay;
        a_row_z  = az;
        a_centre = ac;
        b_row_x  = bx;
        b_row_y  = by;
        b_row_z  = bz;
        b_centre = bc;
        in_valid = 1'b1;
        do
            @(negedge clk);
        while (!in_taken);
        beats_sent++;
    endtask

    // Drops valid for a number of cycles between bursts.
    task automatic sender_gap(int cycles);
        in_valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Sends a pair of random boxes. Most pairs are plausible boxes whose
    // centres sit close enough for the outcome to be in doubt; the rest are
    // raw bit patterns, or boxes at the extremes of the component range.
    task automatic send_random_pair();
        int span, reach, pick;
        logic [W-1:0] ac;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            send_boxes(rand_bits(), rand_bits(), rand_bits(), rand_bits(),
                       rand_bits(), rand_bits(), rand_bits(), rand_bits());
        end
        else
        begin
            span  = (pick < 25) ? 32767 : (1 << $urandom_range(4, 11));
            reach = (pick < 25) ? 32767 : span * 2;
            ac    = rand_row(reach / 2);
            send_boxes(rand_row(span), rand_row(span), rand_row(span), ac,
                       rand_row(span), rand_row(span), rand_row(span),
                       ac + (rand_row(reach) & {W{1'b0}}) + rand_row(reach / 2));
        end
    endtask

    // Receiver: its own stall pattern, in windows that either take every beat
    // or stall at random, plus one long hold-off early in the random stream so
    // that the chain fills and in_ready falls.
    always @(negedge clk)
    begin
        int window_mode;
        if (!rst_n)
        begin
            out_ready   = 1'b0;
            rx_cycle    = 0;
            window_mode = 0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                window_mode = $urandom_range(2);
            if (rx_cycle >= 800 && rx_cycle < 1200)
                out_ready = 1'b0;
            else if (window_mode == 0)
                out_ready = 1'b1;
            else if (window_mode == 1)
                out_ready = ($urandom_range(99) < 70);
            else
                out_ready = ($urandom_range(99) < 25);
        end
    end

    // Watchdog: too many cycles in a row with no beat on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int burst;
        in_valid    = 1'b0;
        a_row_x     = '0;
        a_row_y     = '0;
        a_row_z     = '0;
        a_centre    = '0;
        b_row_x     = '0;
        b_row_y     = '0;
        b_row_z     = '0;
        b_centre    = '0;
        beats_sent  = 0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed beats. Degenerate boxes: all axes zero, so no axis can
        // separate, and every component at -1 with coincident centres.
        send_boxes('0, '0, '0, '0, '0, '0, '0, '0);
        send_boxes({W{1'b1}}, {W{1'b1}}, {W{1'b1}}, {W{1'b1}},
                   {W{1'b1}}, {W{1'b1}}, {W{1'b1}}, {W{1'b1}});
        // Unit cubes sharing a centre.
        send_boxes(pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256), '0,
                   pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256), '0);
        // Unit cubes exactly touching along x: equal sides count as overlap.
        send_boxes(pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256), '0,
                   pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256),
                   pack3(256, 0, 0));
        // One step further apart than touching, then far apart.
        send_boxes(pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256), '0,
                   pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256),
                   pack3(257, 0, 0));
        send_boxes(pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256),
                   pack3(-768, 0, 0),
                   pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256),
                   pack3(768, 0, 0));
        // Box B turned by 45 degrees about z, near and beyond its corner.
        send_boxes(pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256), '0,
                   pack3(181, 181, 0), pack3(-181, 181, 0), pack3(0, 0, 256),
                   pack3(300, 0, 0));
        send_boxes(pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256), '0,
                   pack3(181, 181, 0), pack3(-181, 181, 0), pack3(0, 0, 256),
                   pack3(320, 320, 0));
        // Parallel axes in both boxes, so every cross axis is zero.
        send_boxes(pack3(256, 256, 0), pack3(512, 512, 0), pack3(-256, -256, 0), '0,
                   pack3(256, 256, 0), pack3(128, 128, 0), pack3(256, 256, 0),
                   pack3(0, 0, 10));
        // Extremes of the component range.
        send_boxes(pack3(32767, 32767, 32767), pack3(-32768, -32768, -32768),
                   pack3(32767, -32768, 32767), pack3(-32768, -32768, -32768),
                   pack3(-32768, 32767, -32768), pack3(32767, 32767, 32767),
                   pack3(-32768, -32768, 32767), pack3(32767, 32767, 32767));
        send_boxes(pack3(1, 0, 0), pack3(0, 1, 0), pack3(0, 0, 1),
                   pack3(-32768, -32768, -32768),
                   pack3(1, 0, 0), pack3(0, 1, 0), pack3(0, 0, 1),
                   pack3(32767, 32767, 32767));
        send_boxes(pack3(32767, 0, 0), pack3(0, 32767, 0), pack3(0, 0, 32767),
                   pack3(-32768, 0, 0),
                   pack3(-32768, 0, 0), pack3(0, -32768, 0), pack3(0, 0, -32768),
                   pack3(32767, 0, 0));
        // Alternating bit patterns.
        send_boxes({24{2'b10}}, {24{2'b01}}, {24{2'b10}}, {24{2'b01}},
                   {24{2'b01}}, {24{2'b10}}, {24{2'b01}}, {24{2'b10}});

        // Random stream in bursts of random length; some bursts run back to
        // back with no gap at all.
        while (beats_sent < N_RANDOM + 13)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
                send_random_pair();
            if ($urandom_range(3) != 0)
                sender_gap($urandom_range(1, 12));
        end
        in_valid = 1'b0;

        // Drain: wait for every expected result, then a little longer in case
        // the block emits something unexpected.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        $display("Sent %0d box pairs, %0d results checked, %0d of them overlapping.",
                 beats_sent, results_seen, overlaps_seen);
        $display("Covered touching, degenerate and extreme boxes plus random pairs.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
